// ----- src/rnmf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and codes of the radius neighbor mask finder.
// No dependencies; imported by every module of the block.
package rnmf_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int PIDX_W     = $clog2(MAX_POINTS);
  localparam int COUNT_W    = 13;
  localparam int COORD_W    = 16;
  localparam int ABS_W      = COORD_W;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int RADIUS_W   = 36;
  localparam int MASK_W     = 64;
  localparam int BIT_W      = $clog2(MASK_W);
  localparam int BLK_W      = 6;
  localparam int POINT_W    = 3 * COORD_W;

  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 13'd1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 13'd4096;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 36'd94372;

  // Opcodes of an input item
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_RADIUS      = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [PIDX_W-1:0]         pidx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // Sweep tag that travels alongside the distance pipeline
  typedef struct packed {
    logic  valid;
    pidx_t pidx;
  } tag_t;

  // Compare outcome at the end of the distance pipeline
  typedef struct packed {
    logic  valid;
    pidx_t pidx;
    logic  hit;
  } hit_t;

endpackage

// ----- src/rnmf_point_ram.sv -----
`timescale 1ns / 1ps
// Point store: 4096 x 48-bit simple dual-port memory with a registered read port.
// Uses rnmf_pkg for the point type and depth.
module rnmf_point_ram (
  input  logic              clk,
  input  logic              wr_en,
  input  rnmf_pkg::pidx_t   wr_addr,
  input  rnmf_pkg::point_t  wr_data,
  input  logic              rd_en,
  input  rnmf_pkg::pidx_t   rd_addr,
  output rnmf_pkg::point_t  rd_data
);
  import rnmf_pkg::*;

  point_t mem [MAX_POINTS];
  point_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, held while the sweep is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/rnmf_dist_pipe.sv -----
`timescale 1ns / 1ps
// Squared-distance pipeline: abs differences, squares, then sum and compare.
// Uses rnmf_pkg types; fed by the point store read data.
module rnmf_dist_pipe (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  rnmf_pkg::point_t                  cand,
  input  rnmf_pkg::tag_t                    cand_tag,
  input  rnmf_pkg::point_t                  qpt,
  input  rnmf_pkg::pidx_t                   qidx,
  input  logic [rnmf_pkg::RADIUS_W-1:0]     radius,
  output rnmf_pkg::hit_t                    result
);
  import rnmf_pkg::*;

  logic [ABS_W-1:0] ax_r, ay_r, az_r;
  logic [SQ_W-1:0]  sx_r, sy_r, sz_r;
  tag_t             t2_r, t3_r;
  logic [SUM_W-1:0] sum;

  // absolute difference of one axis
  function automatic logic [ABS_W-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] n;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    n = -d;
    return d[COORD_W] ? n[ABS_W-1:0] : d[ABS_W-1:0];
  endfunction

  // stage A: abs differences
  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r <= abs_diff(cand.x, qpt.x);
      ay_r <= abs_diff(cand.y, qpt.y);
      az_r <= abs_diff(cand.z, qpt.z);
    end
  end

  // stage B: squares
  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r <= ax_r * ax_r;
      sy_r <= ay_r * ay_r;
      sz_r <= az_r * az_r;
    end
  end

  // tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_r <= '0;
      t3_r <= '0;
    end else if (adv) begin
      t2_r <= cand_tag;
      t3_r <= t2_r;
    end
  end

  // stage C: sum and strict compare, self excluded
  assign sum = {2'b00, sx_r} + {2'b00, sy_r} + {2'b00, sz_r};

  always_comb begin
    result.valid = t3_r.valid;
    result.pidx  = t3_r.pidx;
    result.hit   = ({{(RADIUS_W-SUM_W){1'b0}}, sum} < radius) && (t3_r.pidx != qidx);
  end

endmodule

// ----- src/radius_neighbor_mask_finder_unit.sv -----
`timescale 1ns / 1ps
// Radius neighbor mask finder top level: sequencer, mask assembly and output register.
// Load: written to the point store at the transfer edge; the input stays ready while idle.
// Query: states S_QFETCH and S_QLATCH fetch the query point, then one store read per point
// feeds the distance pipeline, and each finished block mask goes to the output register.
// Out-of-range query: S_ERR registers an error result when the output is free. A stalled
// output holds the sweep at each 64-point block end. Reset (rst_n low, synchronous): idle,
// output empty, point_count 1, radius_squared 94372; point store is not cleared.
module radius_neighbor_mask_finder_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic                              cfg_index,
  input  logic [rnmf_pkg::RADIUS_W-1:0]     cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [rnmf_pkg::PIDX_W-1:0]       in_point_index,
  input  logic signed [rnmf_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [rnmf_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [rnmf_pkg::COORD_W-1:0] in_coord_z,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rnmf_pkg::BLK_W-1:0]        out_block_index,
  output logic [rnmf_pkg::MASK_W-1:0]       out_neighbor_mask,
  output logic                              out_last_block,
  output logic                              out_query_error
);
  import rnmf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_QFETCH = 6'b000010,
    S_QLATCH = 6'b000100,
    S_SWEEP  = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_ERR    = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [COUNT_W-1:0]  point_count_r;
  logic [RADIUS_W-1:0] radius_r;
  logic [COUNT_W-1:0]  count_eff;
  logic [COUNT_W-1:0]  count_last;
  pidx_t               qidx_r;
  point_t              qpt_r;
  pidx_t               j_r;
  tag_t                t1_r;
  point_t              rd_data;
  point_t              wr_data;
  pidx_t               rd_addr;
  hit_t                hres;
  logic                in_xfer;
  logic                load_xfer;
  logic                query_xfer;
  logic                query_ok;
  logic                blk_end;
  logic                last_pt;
  logic                adv;
  logic                emit_blk;
  logic                emit_err;
  logic [MASK_W-1:0]   mask_r;
  logic [MASK_W-1:0]   mask_cur;
  logic                out_valid_r;
  logic [BLK_W-1:0]    out_block_index_r;
  logic [MASK_W-1:0]   out_neighbor_mask_r;
  logic                out_last_block_r;
  logic                out_query_error_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= COUNT_RESET;
      radius_r      <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_POINT_COUNT: point_count_r <= cfg_wdata[COUNT_W-1:0];
        CFG_RADIUS:      radius_r      <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  assign count_eff  = (point_count_r > COUNT_MAX) ? COUNT_MAX : point_count_r;
  assign count_last = count_eff - COUNT_W'(1);

  // input handshake
  assign in_ready   = (state_r == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign load_xfer  = in_xfer && (in_opcode == OP_LOAD);
  assign query_xfer = in_xfer && (in_opcode == OP_QUERY);
  assign query_ok   = ({1'b0, in_point_index} < count_eff);

  // end of block and end of sweep at the pipeline tail
  assign blk_end = (hres.pidx[BIT_W-1:0] == {BIT_W{1'b1}}) || last_pt;
  assign last_pt = ({1'b0, hres.pidx} == count_last);

  // the sweep halts only when a finished block meets a full output register
  assign adv      = !(hres.valid && blk_end && out_valid_r && !out_ready);
  assign emit_blk = hres.valid && blk_end && adv;
  assign emit_err = (state_r == S_ERR) && (!out_valid_r || out_ready);

  // point store
  assign wr_data = '{x: in_coord_x, y: in_coord_y, z: in_coord_z};
  assign rd_addr = (state_r == S_QFETCH) ? qidx_r : j_r;

  rnmf_point_ram u_ram (
    .clk     (clk),
    .wr_en   (load_xfer),
    .wr_addr (in_point_index),
    .wr_data (wr_data),
    .rd_en   (adv),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (query_xfer) begin
          state_nxt = query_ok ? S_QFETCH : S_ERR;
        end
      end
      S_QFETCH: state_nxt = S_QLATCH;
      S_QLATCH: state_nxt = S_SWEEP;
      S_SWEEP: begin
        if (adv && ({1'b0, j_r} == count_last)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (emit_blk && last_pt) begin
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (emit_err) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // query index, query point and sweep counter
  always_ff @(posedge clk) begin
    if (query_xfer) begin
      qidx_r <= in_point_index;
    end
    if (state_r == S_QLATCH) begin
      qpt_r <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r <= '0;
    end else if (state_r == S_QLATCH) begin
      j_r <= '0;
    end else if ((state_r == S_SWEEP) && adv) begin
      j_r <= j_r + PIDX_W'(1);
    end
  end

  // tag of the read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
    end else if (adv) begin
      t1_r <= '{valid: (state_r == S_SWEEP), pidx: j_r};
    end
  end

  rnmf_dist_pipe u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .cand     (rd_data),
    .cand_tag (t1_r),
    .qpt      (qpt_r),
    .qidx     (qidx_r),
    .radius   (radius_r),
    .result   (hres)
  );

  // mask assembly
  assign mask_cur = mask_r | ({{(MASK_W-1){1'b0}}, hres.hit} << hres.pidx[BIT_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (hres.valid && adv) begin
      mask_r <= blk_end ? '0 : mask_cur;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_blk || emit_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_blk) begin
      out_block_index_r   <= hres.pidx[PIDX_W-1:BIT_W];
      out_neighbor_mask_r <= mask_cur;
      out_last_block_r    <= last_pt;
      out_query_error_r   <= 1'b0;
    end else if (emit_err) begin
      out_block_index_r   <= '0;
      out_neighbor_mask_r <= '0;
      out_last_block_r    <= 1'b1;
      out_query_error_r   <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_index   = out_block_index_r;
  assign out_neighbor_mask = out_neighbor_mask_r;
  assign out_last_block    = out_last_block_r;
  assign out_query_error   = out_query_error_r;

endmodule

// ----- test/tb_radius_neighbor_mask_finder_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for radius_neighbor_mask_finder_unit: directed table, store
// fill, then randomized configuration phases checked by an in-bench predictor.
// Depends on rnmf_pkg and the radius_neighbor_mask_finder_unit RTL.
module tb_radius_neighbor_mask_finder_unit;
  import rnmf_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_OFF_LEN  = 400;
  localparam int FILL_POINTS   = 80;
  localparam logic [RADIUS_W-1:0] RADIUS_ALL = {RADIUS_W{1'b1}};
  localparam coord_t COORD_HI = 16'h7FFF;
  localparam coord_t COORD_LO = 16'h8000;

  // One result transfer: mask of one 64-point block
  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [MASK_W-1:0] mask;
    logic              last;
    logic              err;
  } mask_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // Directed table row: an input item or a register write
  typedef struct {
    row_kind_t           kind;
    logic                op;
    pidx_t               idx;
    coord_t              x;
    coord_t              y;
    coord_t              z;
    logic                reg_sel;
    logic [RADIUS_W-1:0] reg_val;
    bit                  typed;
    mask_result_t        want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic                cfg_index;
  logic [RADIUS_W-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                in_opcode;
  pidx_t               in_point_index;
  coord_t              in_coord_x;
  coord_t              in_coord_y;
  coord_t              in_coord_z;
  logic                out_valid;
  logic                out_ready;
  logic [BLK_W-1:0]    out_block_index;
  logic [MASK_W-1:0]   out_neighbor_mask;
  logic                out_last_block;
  logic                out_query_error;

  // Predictor state: point store and register copies
  point_t              pstore [MAX_POINTS];
  logic [COUNT_W-1:0]  cur_count;
  logic [RADIUS_W-1:0] cur_radius;
  mask_result_t        expected_masks [$];
  stim_row_t           directed [$];

  int fail_count   = 0;
  int report_count = 0;
  int cycle_count  = 0;
  int hold_off_len = 0;
  bit send_steady  = 1'b0;
  bit sink_steady  = 1'b0;

  always #5 clk = ~clk;

  radius_neighbor_mask_finder_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_point_index    (in_point_index),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_coord_z        (in_coord_z),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_block_index   (out_block_index),
    .out_neighbor_mask (out_neighbor_mask),
    .out_last_block    (out_last_block),
    .out_query_error   (out_query_error)
  );

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Coordinate within +-400 LSB of c, clamped to the Q4.11 range
  function automatic coord_t near_coord(coord_t c);
    int v;
    v = int'(c) + int'($urandom_range(0, 800)) - 400;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  function automatic logic [RADIUS_W-1:0] near_radius();
    int s;
    s = $urandom_range(100, 1500);
    return RADIUS_W'(s * s);
  endfunction

  function automatic longint unsigned sq_dist(point_t a, point_t b);
    coord_t ax, ay, az, bx, by, bz;
    longint dx, dy, dz;
    ax = a.x; ay = a.y; az = a.z;
    bx = b.x; by = b.y; bz = b.z;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    dz = longint'(az) - longint'(bz);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Append one expectation at the tail of the scoreboard
  function automatic void queue_expected(mask_result_t res);
    expected_masks.insert(expected_masks.size(), res);
  endfunction

  // Neighbor masks of point qidx under the current registers
  function automatic void compute_neighbors(pidx_t qidx);
    int eff;
    int blocks;
    mask_result_t res;
    eff = (cur_count > COUNT_MAX) ? MAX_POINTS : int'(cur_count);
    if (int'(qidx) >= eff) begin
      res = '{blk: '0, mask: '0, last: 1'b1, err: 1'b1};
      queue_expected(res);
      return;
    end
    blocks = (eff + MASK_W - 1) / MASK_W;
    for (int b = 0; b < blocks; b++) begin
      res = '0;
      res.blk = BLK_W'(b);
      for (int k = 0; k < MASK_W; k++) begin
        int j;
        j = b * MASK_W + k;
        if (j < eff && j != int'(qidx) && sq_dist(pstore[j], pstore[qidx]) < cur_radius)
          res.mask[k] = 1'b1;
      end
      res.last = (b == blocks - 1);
      queue_expected(res);
    end
  endfunction

  function automatic stim_row_t item_row(logic op, pidx_t idx, coord_t x, coord_t y, coord_t z);
    stim_row_t r;
    r.kind    = ROW_ITEM;
    r.op      = op;
    r.idx     = idx;
    r.x       = x;
    r.y       = y;
    r.z       = z;
    r.reg_sel = CFG_POINT_COUNT;
    r.reg_val = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  // Query whose single result is known by inspection
  function automatic stim_row_t checked_row(pidx_t idx, logic [MASK_W-1:0] mask, logic err);
    stim_row_t r;
    r = item_row(OP_QUERY, idx, '0, '0, '0);
    r.typed = 1'b1;
    r.want  = '{blk: '0, mask: mask, last: 1'b1, err: err};
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic sel, logic [RADIUS_W-1:0] val);
    stim_row_t r;
    r = item_row(OP_LOAD, '0, '0, '0, '0);
    r.kind    = ROW_REG;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  // Offer one item and hold it until the transfer, then update the predictor
  task automatic offer_item(logic op, pidx_t idx, coord_t x, coord_t y, coord_t z,
                            bit typed, mask_result_t want);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_point_index <= idx;
    in_coord_x     <= x;
    in_coord_y     <= y;
    in_coord_z     <= z;
    do begin
      @(posedge clk);
    end while (in_ready !== 1'b1);
    if (op == OP_LOAD) pstore[idx] = '{x: x, y: y, z: z};
    else if (typed) queue_expected(want);
    else compute_neighbors(idx);
  endtask

  task automatic sender_gap();
    int n;
    n = pick_gap(send_steady);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop sending and let every pending result drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_masks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic sel, logic [RADIUS_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (sel == CFG_POINT_COUNT) cur_count = val[COUNT_W-1:0];
    else cur_radius = val;
  endtask

  // One configuration setting followed by random loads and queries
  task automatic run_phase(logic [COUNT_W-1:0] count, logic [RADIUS_W-1:0] radius,
                           int n_items, bit steady, int hold_at);
    int eff;
    int r;
    int j;
    logic op;
    pidx_t idx;
    coord_t x, y, z;
    write_reg(CFG_POINT_COUNT, RADIUS_W'(count));
    write_reg(CFG_RADIUS, radius);
    send_steady = steady;
    sink_steady = steady;
    eff = (cur_count > COUNT_MAX) ? MAX_POINTS : int'(cur_count);
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_off_len = HOLD_OFF_LEN;
      r = $urandom_range(0, 99);
      if (r < 30) begin
        // load, mostly close to a point that takes part in queries
        op = OP_LOAD;
        idx = (eff > 0 && $urandom_range(0, 3) != 0) ? PIDX_W'($urandom_range(0, eff - 1))
                                                      : PIDX_W'($urandom());
        if ($urandom_range(0, 7) == 0) begin
          x = coord_t'($urandom()); y = coord_t'($urandom()); z = coord_t'($urandom());
        end else begin
          j = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
          x = near_coord(pstore[j].x);
          y = near_coord(pstore[j].y);
          z = near_coord(pstore[j].z);
        end
      end else begin
        op = OP_QUERY;
        x = '0; y = '0; z = '0;
        if (eff == 0 || (eff < MAX_POINTS && r >= 90))
          idx = PIDX_W'($urandom_range(eff, MAX_POINTS - 1));
        else idx = PIDX_W'($urandom_range(0, eff - 1));
      end
      offer_item(op, idx, x, y, z, 1'b0, '0);
      sender_gap();
    end
    send_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Result side readiness, with an occasional long hold-off on request
  initial begin : result_sink
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_len) @(negedge clk);
        hold_off_len = 0;
      end else begin
        n = pick_gap(sink_steady);
        out_ready <= (n == 0);
        if (n > 0) repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    mask_result_t got;
    mask_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{blk: out_block_index, mask: out_neighbor_mask,
              last: out_last_block, err: out_query_error};
      if (expected_masks.size() == 0) begin
        fail_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("unexpected result: block %0d mask %h last %b err %b",
                   got.blk, got.mask, got.last, got.err);
        end
      end else begin
        want = expected_masks.pop_front();
        if (got.blk !== want.blk || got.mask !== want.mask ||
            got.last !== want.last || got.err !== want.err) begin
          fail_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("mismatch: expected block %0d mask %h last %b err %b",
                     want.blk, want.mask, want.last, want.err);
            $display("          actual   block %0d mask %h last %b err %b",
                     got.blk, got.mask, got.last, got.err);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    point_t center;
    logic [63:0] wide;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_POINT_COUNT;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_opcode      = OP_LOAD;
    in_point_index = '0;
    in_coord_x     = '0;
    in_coord_y     = '0;
    in_coord_z     = '0;
    cur_count      = COUNT_RESET;
    cur_radius     = RADIUS_RESET;

    // Directed rows; only points already loaded are ever read
    directed = '{
      item_row(OP_LOAD, '0, COORD_HI, COORD_HI, COORD_HI),
      checked_row('0, '0, 1'b0),                       // lone point: no neighbors
      checked_row(12'd1, '0, 1'b1),                    // out of range
      checked_row(12'hFFF, '0, 1'b1),
      item_row(OP_LOAD, 12'hFFF, COORD_LO, COORD_LO, COORD_LO),  // beyond count
      item_row(OP_LOAD, 12'd1, COORD_LO, COORD_LO, COORD_LO),
      item_row(OP_LOAD, 12'd2, COORD_HI, COORD_HI, 16'h7FFE),
      item_row(OP_LOAD, 12'd3, COORD_HI, COORD_HI, COORD_HI),    // same spot as 0
      item_row(OP_LOAD, 12'd4, '0, '0, '0),
      item_row(OP_LOAD, 12'd5, 16'h5555, 16'hAAAA, 16'd307),
      reg_row(CFG_POINT_COUNT, '0),
      checked_row('0, '0, 1'b1),                       // zero count: all out of range
      reg_row(CFG_POINT_COUNT, 36'd6),
      item_row(OP_QUERY, '0, '0, '0, '0),
      item_row(OP_QUERY, 12'd4, '0, '0, '0),
      item_row(OP_QUERY, 12'd5, '0, '0, '0),
      reg_row(CFG_RADIUS, '0),
      checked_row(12'd3, '0, 1'b0),                    // zero radius: even distance 0 fails
      reg_row(CFG_RADIUS, RADIUS_ALL),
      checked_row(12'd1, 64'h3D, 1'b0),                // everyone but self
      checked_row(12'd6, '0, 1'b1),
      reg_row(CFG_RADIUS, 36'd1),
      item_row(OP_QUERY, '0, '0, '0, '0)
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG) begin
        write_reg(directed[i].reg_sel, directed[i].reg_val);
      end else begin
        offer_item(directed[i].op, directed[i].idx, directed[i].x, directed[i].y,
                   directed[i].z, directed[i].typed, directed[i].want);
        sender_gap();
      end
    end

    // Fill the low store slots in clusters of 16 so that every point a later sweep reads is loaded
    for (int i = 0; i < FILL_POINTS; i++) begin
      if (i % 16 == 0) begin
        center.x = coord_t'($urandom());
        center.y = coord_t'($urandom());
        center.z = coord_t'($urandom());
      end
      offer_item(OP_LOAD, PIDX_W'(i), near_coord(center.x), near_coord(center.y),
                 near_coord(center.z), 1'b0, '0);
      sender_gap();
    end

    wide = {$urandom(), $urandom()};
    run_phase(COUNT_W'($urandom_range(2, FILL_POINTS)), RADIUS_RESET, 8, 1'b0, -1);
    run_phase(COUNT_W'(64), near_radius(), 6, 1'b1, -1);
    run_phase(COUNT_W'(FILL_POINTS), near_radius(), 4, 1'b0, -1);
    run_phase('0, near_radius(), 3, 1'b0, -1);
    run_phase(COUNT_W'($urandom_range(65, FILL_POINTS)), '0, 4, 1'b1, -1);
    run_phase(COUNT_W'($urandom_range(1, FILL_POINTS)), wide[RADIUS_W-1:0], 5, 1'b0, -1);
    // long output stall while items keep coming
    run_phase(COUNT_W'($urandom_range(1, FILL_POINTS)), near_radius(), 14, 1'b0, 4);

    wait_idle();
    repeat (16) @(posedge clk);
    if (expected_masks.size() != 0) begin
      fail_count += expected_masks.size();
      $display("%0d expected results never arrived", expected_masks.size());
    end
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/rnmf_pkg.sv
src/rnmf_point_ram.sv
src/rnmf_dist_pipe.sv
src/radius_neighbor_mask_finder_unit.sv
test/tb_radius_neighbor_mask_finder_unit.sv
